FILE: rtl/dlle_pkg.sv
// Shared types and constants for the doubly linked list engine.
// No dependencies; every other file of the block refers to this package.
package dlle_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed payload widths of the request and response channels
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_READ    = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_FIRST   = 3'd4,
    ACT_LAST    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   read_value;
    logic [TOTAL_W-1:0]   entry_total;
  } result_t;

endpackage

FILE: rtl/dlle_in_if.sv
// Request channel of the list engine: valid/ready plus action payload.
// Depends on dlle_pkg for the payload widths.
interface dlle_in_if;
  logic                          valid;
  logic                          ready;
  logic [dlle_pkg::ACTION_W-1:0] action;
  logic [dlle_pkg::VALUE_W-1:0]  element_value;
  logic [dlle_pkg::POS_W-1:0]    position;

  modport source (output valid, action, element_value, position, input ready);
  modport sink   (input valid, action, element_value, position, output ready);
endinterface

FILE: rtl/dlle_out_if.sv
// Response channel of the list engine: valid/ready plus result payload.
// Depends on dlle_pkg for the payload widths.
interface dlle_out_if;
  logic                          valid;
  logic                          ready;
  logic [dlle_pkg::STATUS_W-1:0] status;
  logic [dlle_pkg::VALUE_W-1:0]  read_value;
  logic [dlle_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, status, read_value, entry_total, input ready);
  modport sink   (input valid, status, read_value, entry_total, output ready);
endinterface

FILE: rtl/dlle_out_reg.sv
// Response holding register: keeps one result until the sink takes it.
// Depends on dlle_pkg (result_t) and dlle_out_if.
module dlle_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dlle_pkg::result_t res,
  output logic              room,
  dlle_out_if.source        rsp
);

  dlle_pkg::result_t held;

  // a new result may enter when the slot is empty or drains this cycle
  assign room = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

  assign rsp.status      = held.status;
  assign rsp.read_value  = held.read_value;
  assign rsp.entry_total = held.entry_total;

endmodule

FILE: rtl/doubly_linked_list_engine_core.sv
// Doubly linked list engine: ordered list of up to DEPTH entries in a node pool.
// Depends on dlle_pkg, dlle_in_if, dlle_out_if and dlle_out_reg.
//
// Usage:
//   req carries one action per transfer (append, prepend, read at position,
//   remove at position, read first, read last). rsp returns exactly one result
//   per request: status, the value read (zero unless a read succeeds) and the
//   entry count after the action.
//   Nodes live in a value RAM and a link RAM (next/prev), both read through
//   a register. One request is in flight at a time; req.ready is high only
//   while the engine waits for work. The next request is taken in the cycle
//   after the result is loaded. States per request: append/prepend DECODE,
//   POP (free list not empty), INS_NODE, INS_LINK (list not empty), FINISH;
//   read first/last DECODE, FETCH, FINISH; read/remove by position DECODE,
//   one WALK step per link, at most (DEPTH+1)/2 - 1 links with one link RAM
//   read per cycle, FETCH, for remove REM_PREV, REM_NEXT, REM_FREE, FINISH;
//   rejected ones (empty, out of range, full, unknown action) DECODE, FINISH.
//   Reset empties the list at once; RAM contents are left as they are and
//   unused slots are handed out from a fill counter, so no clearing pass.
//   A stalled rsp holds its result; the engine then waits with the next
//   result until the register frees, but a held result does not block a
//   new request from being taken.
module doubly_linked_list_engine_core #(
  parameter int DEPTH      = dlle_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dlle_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dlle_in_if.sink    req,
  dlle_out_if.source rsp
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > dlle_pkg::POS_W) ? CW : dlle_pkg::POS_W;

  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [SW-1:0] prv;
  } link_t;

  typedef enum logic [3:0] {
    IDLE, DECODE, POP, INS_NODE, INS_LINK, WALK, FETCH,
    REM_PREV, REM_NEXT, REM_FREE, FINISH
  } state_t;

  state_t            state;
  dlle_pkg::action_t act;
  logic [DATA_WIDTH-1:0] val;
  logic [dlle_pkg::POS_W-1:0] pos;

  logic [SW-1:0] head, tail, free_head, cur, steps, pslot, nslot;
  logic [CW-1:0] count, fresh, free_cnt;
  logic          fwd;
  dlle_pkg::status_t     res_status;
  logic [DATA_WIDTH-1:0] res_value;

  // node storage
  logic [DATA_WIDTH-1:0] value_mem [DEPTH];
  link_t                 link_mem  [DEPTH];
  logic [DATA_WIDTH-1:0] val_rd;
  link_t                 link_rd;

  logic [SW-1:0] rd_addr, lw_addr, lw_nxt, lw_prv;
  logic          lw_nxt_en, lw_prv_en;

  logic          in_range, from_head, is_ins, is_last, out_room, out_load;
  logic [SW-1:0] start_slot, walk_steps, walk_next;
  dlle_pkg::result_t res;

  // ---------------------------------------------------------------------
  // Decode helpers
  // ---------------------------------------------------------------------
  assign in_range  = PW'(pos) < PW'(count);
  assign from_head = PW'(pos) < PW'(count >> 1);
  assign is_ins    = (act == dlle_pkg::ACT_APPEND) || (act == dlle_pkg::ACT_PREPEND);
  assign is_last   = CW'(pos) == (count - CW'(1));
  assign walk_next = fwd ? link_rd.nxt : link_rd.prv;

  always_comb begin
    priority if (act == dlle_pkg::ACT_FIRST) begin
      start_slot = head;
      walk_steps = '0;
    end else if (act == dlle_pkg::ACT_LAST) begin
      start_slot = tail;
      walk_steps = '0;
    end else if (from_head) begin
      start_slot = head;
      walk_steps = SW'(pos);
    end else begin
      start_slot = tail;
      walk_steps = SW'(count - CW'(1) - CW'(pos));
    end
  end

  // one read address drives both RAMs
  always_comb begin
    unique case (state)
      DECODE:  rd_addr = is_ins ? free_head : start_slot;
      WALK:    rd_addr = walk_next;
      default: rd_addr = cur;
    endcase
  end

  // link RAM write port, next and prev fields enabled separately
  always_comb begin
    lw_nxt_en = 1'b0;
    lw_prv_en = 1'b0;
    lw_addr   = cur;
    lw_nxt    = head;
    lw_prv    = tail;
    unique case (state)
      INS_NODE: begin
        lw_nxt_en = 1'b1;
        lw_prv_en = 1'b1;
      end
      INS_LINK: begin
        if (act == dlle_pkg::ACT_APPEND) begin
          lw_nxt_en = 1'b1;
          lw_addr   = tail;
          lw_nxt    = cur;
        end else begin
          lw_prv_en = 1'b1;
          lw_addr   = head;
          lw_prv    = cur;
        end
      end
      REM_PREV: begin
        lw_nxt_en = (pos != '0);
        lw_addr   = pslot;
        lw_nxt    = nslot;
      end
      REM_NEXT: begin
        lw_prv_en = !is_last;
        lw_addr   = nslot;
        lw_prv    = pslot;
      end
      REM_FREE: begin
        lw_nxt_en = 1'b1;
        lw_nxt    = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == INS_NODE) begin
      value_mem[cur] <= val;
    end
    if (lw_nxt_en) begin
      link_mem[lw_addr].nxt <= lw_nxt;
    end
    if (lw_prv_en) begin
      link_mem[lw_addr].prv <= lw_prv;
    end
    val_rd  <= value_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign req.ready = (state == IDLE);
  assign out_load  = (state == FINISH) && out_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      fresh     <= '0;
      free_cnt  <= '0;
      free_head <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            act   <= dlle_pkg::action_t'(req.action);
            val   <= DATA_WIDTH'(req.element_value);
            pos   <= req.position;
            state <= DECODE;
          end
        end
        DECODE: begin
          res_status <= dlle_pkg::ST_OK;
          res_value  <= '0;
          unique case (act)
            dlle_pkg::ACT_APPEND, dlle_pkg::ACT_PREPEND: begin
              if (count == CW'(DEPTH)) begin
                res_status <= dlle_pkg::ST_FULL;
                state      <= FINISH;
              end else if (free_cnt != '0) begin
                state <= POP;  // free-list head read is in flight
              end else begin
                cur   <= SW'(fresh);
                fresh <= fresh + CW'(1);
                state <= INS_NODE;
              end
            end
            dlle_pkg::ACT_READ, dlle_pkg::ACT_REMOVE,
            dlle_pkg::ACT_FIRST, dlle_pkg::ACT_LAST: begin
              // first/last ignore the position field
              if (count == '0 || (!in_range &&
                  (act == dlle_pkg::ACT_READ || act == dlle_pkg::ACT_REMOVE))) begin
                res_status <= dlle_pkg::ST_NOT_FOUND;
                state      <= FINISH;
              end else begin
                cur   <= start_slot;
                fwd   <= from_head;
                steps <= walk_steps;
                state <= (walk_steps == '0) ? FETCH : WALK;
              end
            end
            default: begin
              res_status <= dlle_pkg::ST_NOT_FOUND;
              state      <= FINISH;
            end
          endcase
        end
        POP: begin
          cur       <= free_head;
          free_head <= link_rd.nxt;
          free_cnt  <= free_cnt - CW'(1);
          state     <= INS_NODE;
        end
        INS_NODE: begin
          if (count == '0) begin
            head  <= cur;
            tail  <= cur;
            count <= count + CW'(1);
            state <= FINISH;
          end else begin
            state <= INS_LINK;
          end
        end
        INS_LINK: begin
          if (act == dlle_pkg::ACT_APPEND) begin
            tail <= cur;
          end else begin
            head <= cur;
          end
          count <= count + CW'(1);
          state <= FINISH;
        end
        WALK: begin
          // the read at walk_next issued now is the next hop or the target
          cur   <= walk_next;
          steps <= steps - SW'(1);
          if (steps == SW'(1)) begin
            state <= FETCH;
          end
        end
        FETCH: begin
          if (act == dlle_pkg::ACT_REMOVE) begin
            pslot <= link_rd.prv;
            nslot <= link_rd.nxt;
            state <= REM_PREV;
          end else begin
            res_value <= val_rd;
            state     <= FINISH;
          end
        end
        REM_PREV: begin
          if (pos == '0) begin
            head <= nslot;
          end
          state <= REM_NEXT;
        end
        REM_NEXT: begin
          if (is_last) begin
            tail <= pslot;
          end
          state <= REM_FREE;
        end
        REM_FREE: begin
          free_head <= cur;
          free_cnt  <= free_cnt + CW'(1);
          count     <= count - CW'(1);
          state     <= FINISH;
        end
        FINISH: begin
          if (out_room) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign res.status      = res_status;
  assign res.read_value  = dlle_pkg::VALUE_W'(res_value);
  assign res.entry_total = dlle_pkg::TOTAL_W'(count);

  dlle_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .res  (res),
    .room (out_room),
    .rsp  (rsp)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above pool size");

  a_slot_accounting: assert property (@(posedge clk) disable iff (rst)
    state == IDLE |-> ({1'b0, count} + {1'b0, free_cnt}) == {1'b0, fresh})
    else $error("slots lost or duplicated between list and free list");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == DECODE)
    else $error("accepted request not decoded");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    state == WALK |-> steps != '0)
    else $error("walk with no hops left");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> rsp.valid && state == IDLE)
    else $error("result not presented after finish");

endmodule
